// ----- rtl/skc_pkg.sv -----
// ----------------------------------------------------------------------------
// skc_pkg
// Shared widths, register codes and pipeline control type of the cubic
// spline kernel texel generator.
// ----------------------------------------------------------------------------
package skc_pkg;

	// Texel coordinate, squared radius, radius and normalized radius widths.
	localparam int COORD_W = 8;
	localparam int SQ_W    = 16;
	localparam int R_W     = 16;
	localparam int U_W     = 17;
	localparam int REG_W   = 18;
	localparam int IDX_W   = 2;
	localparam int OUT_W   = 8;

	// One in Q1.16.
	localparam logic [U_W-1:0] ONE_Q16 = 17'h10000;

	// Reset value of both registers (0.5 in Q2.16).
	localparam logic [REG_W-1:0] REG_RESET = 18'd32768;

	// Register indexes on the configuration port.
	typedef enum logic [IDX_W-1:0] {
		REG_SMOOTHING_LENGTH = 2'd0,
		REG_KERNEL_SCALE     = 2'd1
	} skc_reg_t;

	// Control that travels with each request through the kernel stages.
	typedef struct packed {
		logic valid;
		logic zero;
		logic lower;
	} skc_ctl_t;

endpackage

// ----- rtl/skc_sqrt.sv -----
// ----------------------------------------------------------------------------
// skc_sqrt
// Pipelined digit-by-digit square root: root = floor(sqrt(sum_sq * 2^16)),
// two result bits per stage over eight stages.
// ----------------------------------------------------------------------------
module skc_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [skc_pkg::SQ_W-1:0] sum_sq,
	output logic                     out_valid,
	output logic [skc_pkg::R_W-1:0]  root
);
	import skc_pkg::*;

	localparam int STAGES = R_W / 2;
	localparam int NUM_W  = 2 * R_W;
	localparam int REM_W  = R_W + 2;

	logic             vld_s  [STAGES];
	logic [REM_W-1:0] rem_s  [STAGES];
	logic [R_W-1:0]   root_s [STAGES];
	logic [NUM_W-1:0] num_s  [STAGES];

	genvar g;
	for (g = 0; g < STAGES; g++) begin : g_stage
		logic             vld_i;
		logic [REM_W-1:0] rem_i;
		logic [R_W-1:0]   root_i;
		logic [NUM_W-1:0] num_i;
		logic [REM_W-1:0] rem_d;
		logic [R_W-1:0]   root_d;
		logic [NUM_W-1:0] num_d;

		// Stage inputs come from the ports or from the previous stage.
		if (g == 0) begin : g_first
			assign vld_i  = in_valid;
			assign rem_i  = '0;
			assign root_i = '0;
			assign num_i  = {sum_sq, {(NUM_W - SQ_W){1'b0}}};
		end else begin : g_next
			assign vld_i  = vld_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign num_i  = num_s[g-1];
		end

		// Two trial subtractions, each bringing down two bits of the radicand.
		always_comb begin
			logic [REM_W+1:0] acc;
			logic [REM_W+1:0] trial;
			rem_d  = rem_i;
			root_d = root_i;
			num_d  = num_i;
			for (int k = 0; k < 2; k++) begin
				acc   = {rem_d, num_d[NUM_W-1 -: 2]};
				trial = {2'b00, root_d, 2'b01};
				num_d = {num_d[NUM_W-3:0], 2'b00};
				if (acc >= trial) begin
					acc    = acc - trial;
					root_d = {root_d[R_W-2:0], 1'b1};
				end else begin
					root_d = {root_d[R_W-2:0], 1'b0};
				end
				rem_d = acc[REM_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= rem_d;
			root_s[g] <= root_d;
			num_s[g]  <= num_d;
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign root      = root_s[STAGES-1];

endmodule

// ----- rtl/skc_div.sv -----
// ----------------------------------------------------------------------------
// skc_div
// Pipelined restoring divider u = floor(r * 2^16 / h) with the branch
// decisions of the kernel, two quotient bits per stage.
// ----------------------------------------------------------------------------
module skc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [skc_pkg::R_W-1:0]   radius,
	input  logic [skc_pkg::REG_W-1:0] smooth_len,
	output skc_pkg::skc_ctl_t         ctl,
	output logic [skc_pkg::U_W-1:0]   quot
);
	import skc_pkg::*;

	localparam int FRAC   = U_W - 1;
	localparam int STAGES = FRAC / 2;

	logic [REG_W-1:0] r_ext;
	logic             r_ge_h;

	skc_ctl_t         ctl_s0;
	logic [REG_W-1:0] rem_s0;
	logic [U_W-1:0]   q_s0;

	skc_ctl_t         ctl_s  [STAGES];
	logic [REG_W-1:0] rem_s  [STAGES];
	logic [U_W-1:0]   q_s    [STAGES];

	assign r_ext  = {{(REG_W - R_W){1'b0}}, radius};
	assign r_ge_h = (r_ext >= smooth_len);

	// Entry stage: branch flags, integer quotient bit and first remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else begin
			ctl_s0.valid <= in_valid;
			ctl_s0.zero  <= (smooth_len == '0) || (r_ext > smooth_len);
			ctl_s0.lower <= ({r_ext, 1'b0} < {1'b0, smooth_len});
		end
	end

	always_ff @(posedge clk) begin
		rem_s0 <= r_ge_h ? (r_ext - smooth_len) : r_ext;
		q_s0   <= {{(U_W - 1){1'b0}}, r_ge_h};
	end

	genvar g;
	for (g = 0; g < STAGES; g++) begin : g_stage
		skc_ctl_t         ctl_i;
		logic [REG_W-1:0] rem_i;
		logic [U_W-1:0]   q_i;
		logic [REG_W-1:0] rem_d;
		logic [U_W-1:0]   q_d;

		if (g == 0) begin : g_first
			assign ctl_i = ctl_s0;
			assign rem_i = rem_s0;
			assign q_i   = q_s0;
		end else begin : g_next
			assign ctl_i = ctl_s[g-1];
			assign rem_i = rem_s[g-1];
			assign q_i   = q_s[g-1];
		end

		// Two shift-and-subtract steps of the long division.
		always_comb begin
			logic [REG_W:0] acc;
			rem_d = rem_i;
			q_d   = q_i;
			for (int k = 0; k < 2; k++) begin
				acc = {rem_d, 1'b0};
				if (acc >= {1'b0, smooth_len}) begin
					acc = acc - {1'b0, smooth_len};
					q_d = {q_d[U_W-2:0], 1'b1};
				end else begin
					q_d = {q_d[U_W-2:0], 1'b0};
				end
				rem_d = acc[REG_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else begin
				ctl_s[g] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= rem_d;
			q_s[g]   <= q_d;
		end
	end

	assign ctl  = ctl_s[STAGES-1];
	assign quot = q_s[STAGES-1];

endmodule

// ----- rtl/sph_kernel_texture_pixel.sv -----
// ----------------------------------------------------------------------------
// sph_kernel_texture_pixel
// Cubic spline kernel texel generator: one texel coordinate in, one 8-bit
// intensity out, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction
//  request   start, busy, row_index, col_index    in (busy out)
//  result    done, intensity                      out
//  config    cfg_we, cfg_index, cfg_data          in
//
// A request is taken in every cycle; busy is always low. Each result passes
// through the squared radius register, the square root stages, the divider
// stages and the kernel polynomial and scaling multiplier registers. done is
// high for one cycle with each result. Reset clears the valid bits and sets
// both registers to 0.5.
// ----------------------------------------------------------------------------
module sph_kernel_texture_pixel (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [skc_pkg::COORD_W-1:0] row_index,
	input  logic [skc_pkg::COORD_W-1:0] col_index,
	output logic                      done,
	output logic [skc_pkg::OUT_W-1:0] intensity,
	input  logic                      cfg_we,
	input  logic [skc_pkg::IDX_W-1:0] cfg_index,
	input  logic [skc_pkg::REG_W-1:0] cfg_data
);
	import skc_pkg::*;

	localparam int KL_W = U_W + 4;
	localparam int P_W  = REG_W + U_W;
	localparam int M_W  = P_W + 8;

	logic [REG_W-1:0] smooth_q;
	logic [REG_W-1:0] scale_q;

	logic              vld_s1;
	logic [SQ_W-1:0]   sum_s1;
	logic              r_vld;
	logic [R_W-1:0]    r_val;
	skc_ctl_t          dctl;
	logic [U_W-1:0]    u_val;

	skc_ctl_t          ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [U_W-1:0]    w_s2, sq_s2, sq_s3, cube_s3, k_s4;
	logic [P_W-1:0]    p_s5;

	logic signed [COORD_W-1:0] x_c, y_c;
	logic [U_W-1:0]    w_c;
	logic [2*U_W-1:0]  sq_full, cube_full;
	logic [KL_W-1:0]   kl_c;
	logic [U_W:0]      ku_c;
	logic [U_W-1:0]    k_c;
	logic [M_W-1:0]    m_c;
	logic [M_W-33:0]   hi_c;

	assign busy = 1'b0;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= REG_RESET;
			scale_q  <= REG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SMOOTHING_LENGTH: smooth_q <= cfg_data;
				REG_KERNEL_SCALE:     scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Centered coordinates and squared radius.
	assign x_c = {~row_index[COORD_W-1], row_index[COORD_W-2:0]};
	assign y_c = {~col_index[COORD_W-1], col_index[COORD_W-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= SQ_W'(x_c * x_c) + SQ_W'(y_c * y_c);
	end

	skc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.sum_sq    (sum_s1),
		.out_valid (r_vld),
		.root      (r_val)
	);

	skc_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (r_vld),
		.radius     (r_val),
		.smooth_len (smooth_q),
		.ctl        (dctl),
		.quot       (u_val)
	);

	// Polynomial argument and its square.
	assign w_c     = dctl.lower ? u_val : (ONE_Q16 - u_val);
	assign sq_full = w_c * w_c;

	// Cube of the argument.
	assign cube_full = sq_s2 * w_s2;

	// Kernel value of either branch, clamped at zero.
	assign kl_c = KL_W'(ONE_Q16) + KL_W'(6) * {4'b0, cube_s3} - KL_W'(6) * {4'b0, sq_s3};
	assign ku_c = {cube_s3, 1'b0};

	always_comb begin
		if (ctl_s3.zero) begin
			k_c = '0;
		end else if (ctl_s3.lower) begin
			k_c = kl_c[KL_W-1] ? '0 : kl_c[U_W-1:0];
		end else begin
			k_c = ku_c[U_W-1:0];
		end
	end

	// Times 255, drop the 32 fraction bits and saturate.
	assign m_c  = {p_s5, 8'b0} - {8'b0, p_s5};
	assign hi_c = m_c[M_W-1:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s2 <= dctl;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			done   <= ctl_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		w_s2      <= w_c;
		sq_s2     <= sq_full[U_W+15:16];
		sq_s3     <= sq_s2;
		cube_s3   <= cube_full[U_W+15:16];
		k_s4      <= k_c;
		p_s5      <= scale_q * k_s4;
		intensity <= (hi_c > (M_W-32)'(255)) ? 8'hFF : hi_c[OUT_W-1:0];
	end

endmodule

// ----- bench/tb_sph_kernel_texture_pixel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sph_kernel_texture_pixel
// Self-checking bench for the cubic spline kernel texel generator. Requests
// are sent with random gaps, none in one random phase; the intensity of each
// is predicted from an integer model of the kernel; results are checked in order.
// ----------------------------------------------------------------------------
module tb_sph_kernel_texture_pixel;
	import skc_pkg::*;

	localparam int LATENCY = 23;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [COORD_W-1:0] row_index;
	logic [COORD_W-1:0] col_index;
	logic               done;
	logic [OUT_W-1:0]   intensity;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [REG_W-1:0]   cfg_data;

	// Local copy of the registers.
	logic [REG_W-1:0] h_reg;
	logic [REG_W-1:0] scale_reg;

	logic [OUT_W-1:0] intensity_q[$];
	int               n_err;
	int               n_req;
	int               n_res;
	int               n_cfg;
	bit               no_gaps;

	sph_kernel_texture_pixel u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.row_index (row_index),
		.col_index (col_index),
		.done      (done),
		.intensity (intensity),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Integer square root of a 64-bit value, truncated.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n    = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Expected intensity of one texel under the current registers.
	function automatic logic [OUT_W-1:0] texel_intensity(logic [7:0] ri, logic [7:0] ci);
		longint          xi;
		longint          yi;
		longint unsigned r;
		longint unsigned h;
		longint unsigned u;
		longint unsigned a2;
		longint unsigned a3;
		longint unsigned v;
		longint          k;
		longint unsigned val;
		xi = longint'(ri) - 128;
		yi = longint'(ci) - 128;
		r  = int_sqrt(longint'(xi * xi + yi * yi) << 16);
		h  = h_reg;
		k  = 0;
		if (h != 0 && r <= h) begin
			u = (r << 16) / h;
			if (2 * r < h) begin
				a2 = (u * u) >> 16;
				a3 = (a2 * u) >> 16;
				k  = 65536 - 6 * longint'(a2) + 6 * longint'(a3);
				if (k < 0) k = 0;
			end else begin
				v  = 65536 - u;
				a2 = (v * v) >> 16;
				a3 = (a2 * v) >> 16;
				k  = 2 * a3;
			end
		end
		val = (longint'(scale_reg) * k * 255) >> 32;
		if (val > 255) val = 255;
		return val[7:0];
	endfunction

	// Send one request; the prediction is queued when it is accepted.
	// start stays high afterwards so that requests can follow back to back.
	task automatic send_texel(logic [7:0] ri, logic [7:0] ci);
		while (!no_gaps && $urandom_range(99) < 27) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		row_index <= ri;
		col_index <= ci;
		@(posedge clk);
		while (busy) @(posedge clk);
		intensity_q = {intensity_q, texel_intensity(ri, ci)};
		n_req++;
		@(negedge clk);
	endtask

	// Stop sending, wait for every result, then let the pipeline drain.
	task automatic drain_results();
		start <= 1'b0;
		while (intensity_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(skc_reg_t idx, logic [REG_W-1:0] val);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
		if (idx == REG_SMOOTHING_LENGTH) h_reg = val;
		else scale_reg = val;
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_res++;
			if (intensity_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, intensity);
				n_err++;
			end else if (intensity !== intensity_q[0]) begin
				$display("%0t: intensity mismatch, expected %0d, actual %0d", $time,
					intensity_q[0], intensity);
				n_err++;
				void'(intensity_q.pop_front());
			end else begin
				void'(intensity_q.pop_front());
			end
		end
	end

	// Corners, center, axis ends and some interior points under reset registers.
	task automatic test_directed();
		send_texel(8'd0, 8'd0);
		send_texel(8'd255, 8'd255);
		send_texel(8'd0, 8'd255);
		send_texel(8'd255, 8'd0);
		send_texel(8'd128, 8'd128);
		send_texel(8'd128, 8'd0);
		send_texel(8'd0, 8'd128);
		send_texel(8'd160, 8'd128);
		send_texel(8'd128, 8'd192);
		send_texel(8'd170, 8'd170);
		send_texel(8'd127, 8'd129);
		send_texel(8'd85, 8'd86);
	endtask

	// Zero smoothing length gives zero everywhere.
	task automatic test_zero_length();
		write_reg(REG_SMOOTHING_LENGTH, '0);
		send_texel(8'd128, 8'd128);
		send_texel(8'd129, 8'd128);
		send_texel(8'd0, 8'd0);
	endtask

	// Large scale and length to force saturation, then a length of one and the smallest scale.
	task automatic test_extremes();
		write_reg(REG_KERNEL_SCALE, 18'h3FFFF);
		write_reg(REG_SMOOTHING_LENGTH, 18'h3FFFF);
		send_texel(8'd128, 8'd128);
		send_texel(8'd0, 8'd0);
		send_texel(8'd200, 8'd50);
		write_reg(REG_SMOOTHING_LENGTH, 18'd1);
		send_texel(8'd128, 8'd128);
		send_texel(8'd129, 8'd128);
		write_reg(REG_KERNEL_SCALE, '0);
		send_texel(8'd128, 8'd128);
		send_texel(8'd100, 8'd140);
	endtask

	// Random texels under several register settings.
	task automatic test_random();
		logic [REG_W-1:0] hv;
		logic [REG_W-1:0] sv;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: hv = REG_W'($urandom_range(262143, 1));
				1: hv = REG_W'($urandom_range(65536, 4096));
				2: hv = 18'h3FFFF;
				default: hv = REG_W'($urandom_range(32768, 16384));
			endcase
			sv = (ph == 3) ? 18'h3FFFF : REG_W'($urandom_range(262143));
			write_reg(REG_SMOOTHING_LENGTH, hv);
			write_reg(REG_KERNEL_SCALE, sv);
			no_gaps = (ph == 5);
			for (int n = 0; n < 150; n++) begin
				send_texel(8'($urandom_range(255)), 8'($urandom_range(255)));
				// Hold off once until every result is back.
				if (ph == 2 && n == 70) begin
					start <= 1'b0;
					while (intensity_q.size() != 0) @(negedge clk);
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		n_err     = 0;
		n_req     = 0;
		n_res     = 0;
		n_cfg     = 0;
		no_gaps   = 1'b0;
		h_reg     = REG_RESET;
		scale_reg = REG_RESET;
		arst_n    = 1'b0;
		start     = 1'b0;
		row_index = '0;
		col_index = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_SMOOTHING_LENGTH;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_zero_length();
		test_extremes();
		test_random();
		drain_results();
		$display("Sent %0d texel requests, checked %0d intensities across %0d register writes.",
			n_req, n_res, n_cfg);
		if (n_err == 0 && intensity_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding.", intensity_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
